### sv/art_pkg.sv
package art_pkg;

	localparam int ADDR_W = 48;
	localparam int LEN_W = 48;
	localparam int PERM_W = 4;
	localparam int SLOT_W = 4;
	localparam int ADDR_BITS = 48;

	localparam int MAX_REGIONS_DEF = 16;
	localparam int PAGE_BYTES_DEF = 4096;

	localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} :
		ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

	typedef enum logic [1:0] {
		REQ_MAP    = 2'd0,
		REQ_LOOKUP = 2'd1,
		REQ_UNMAP  = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_OVERLAP   = 3'd1,
		ST_FULL      = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_PARTIAL   = 3'd4
	} status_t;

	typedef struct packed {
		status_t             status;
		logic                hit;
		logic [SLOT_W-1:0]   slot;
		logic [ADDR_W-1:0]   base;
		logic [LEN_W-1:0]    length;
		logic [PERM_W-1:0]   perm;
	} result_t;

endpackage

### sv/address_region_table_unit.sv
// Table of up to MAX_REGIONS address regions with page-aligned starts. A map item
// rounds its address down to a page, raises its length to one page at least, and
// is refused on any overlap with a stored region or when no slot is free; a lookup
// item returns the region that holds the address; an unmap item removes a region
// only when it names the region's exact start and length. Every item scans all
// slots through the single read port of the table memory, one slot per cycle, and
// no new item is taken until the last one has passed its result on; the next item
// is then taken while that result still sits in the output register. The valid
// marks are cleared at reset, so no clearing pass is needed.
module address_region_table_unit
	import art_pkg::*;
#(
	parameter int MAX_REGIONS = MAX_REGIONS_DEF,
	parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        req_type,
	input  logic [ADDR_W-1:0] addr,
	input  logic [LEN_W-1:0]  length,
	input  logic [PERM_W-1:0] perm,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        status,
	output logic              hit,
	output logic [SLOT_W-1:0] slot,
	output logic [ADDR_W-1:0] region_base,
	output logic [LEN_W-1:0]  region_length,
	output logic [PERM_W-1:0] region_perm
);

	localparam int IDX_W = $clog2(MAX_REGIONS);
	localparam int ENT_W = ADDR_W - $clog2(PAGE_BYTES) + LEN_W + PERM_W;

	logic              ram_re;
	logic [IDX_W-1:0]  ram_raddr;
	logic [ENT_W-1:0]  ram_rdata;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [ENT_W-1:0]  ram_wdata;
	logic              res_valid;
	logic              res_take;
	result_t           res;
	logic              out_valid_q;
	result_t           result_q;

	art_ram #(
		.DEPTH (MAX_REGIONS),
		.WIDTH (ENT_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	art_scan #(
		.MAX_REGIONS (MAX_REGIONS),
		.PAGE_BYTES  (PAGE_BYTES)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.addr      (addr),
		.length    (length),
		.perm      (perm),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	assign res_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			result_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status = result_q.status;
	assign hit = result_q.hit;
	assign slot = result_q.slot;
	assign region_base = result_q.base;
	assign region_length = result_q.length;
	assign region_perm = result_q.perm;

endmodule

### sv/art_ram.sv
module art_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/art_scan.sv
module art_scan
	import art_pkg::*;
#(
	parameter int MAX_REGIONS = MAX_REGIONS_DEF,
	parameter int PAGE_BYTES = PAGE_BYTES_DEF,
	localparam int IDX_W = $clog2(MAX_REGIONS),
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES),
	localparam int PAGE_W = ADDR_W - PAGE_SHIFT,
	localparam int ENT_W = PAGE_W + LEN_W + PERM_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        req_type,
	input  logic [ADDR_W-1:0] addr,
	input  logic [LEN_W-1:0]  length,
	input  logic [PERM_W-1:0] perm,
	output logic              res_valid,
	input  logic              res_take,
	output result_t           res,
	output logic              ram_re,
	output logic [IDX_W-1:0]  ram_raddr,
	input  logic [ENT_W-1:0]  ram_rdata,
	output logic              ram_we,
	output logic [IDX_W-1:0]  ram_waddr,
	output logic [ENT_W-1:0]  ram_wdata
);

	localparam logic [IDX_W-1:0] LAST = IDX_W'(MAX_REGIONS - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_WAIT,
		S_FIN
	} state_t;

	state_t             state_q;
	req_t               type_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [LEN_W-1:0]   len_q;
	logic [ADDR_W-1:0]  start_q;
	logic [LEN_W-1:0]   mlen_q;
	logic [ADDR_W:0]    end_q;
	logic [PERM_W-1:0]  perm_q;
	logic [IDX_W-1:0]   idx_q;
	logic               chk_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               found_q;
	logic [IDX_W-1:0]   fidx_q;
	logic [ADDR_W-1:0]  fbase_q;
	logic [LEN_W-1:0]   flen_q;
	logic [PERM_W-1:0]  fperm_q;
	logic               free_q;
	logic [IDX_W-1:0]   freeidx_q;
	logic               valid_q [MAX_REGIONS];

	logic               accept;
	logic               fire;
	logic [ADDR_W-1:0]  a_m;
	logic [ADDR_W-1:0]  start_c;
	logic [LEN_W-1:0]   mlen_c;
	logic [PAGE_W-1:0]  e_page;
	logic [LEN_W-1:0]   e_len;
	logic [PERM_W-1:0]  e_perm;
	logic [ADDR_W-1:0]  e_base;
	logic [ADDR_W:0]    e_end;
	logic               e_valid;
	logic               match;
	logic               do_map;
	logic               do_unmap;

	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && (state_q == S_IDLE);
	assign res_valid = (state_q == S_FIN);
	assign fire = res_valid && res_take;

	assign a_m = addr & ADDR_MASK;
	assign start_c = {a_m[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
	assign mlen_c = (length < LEN_W'(PAGE_BYTES)) ? LEN_W'(PAGE_BYTES) : length;

	assign ram_re = (state_q == S_SCAN);
	assign ram_raddr = idx_q;

	assign e_page = ram_rdata[ENT_W-1 -: PAGE_W];
	assign e_len = ram_rdata[PERM_W +: LEN_W];
	assign e_perm = ram_rdata[PERM_W-1:0];
	assign e_base = {e_page, {PAGE_SHIFT{1'b0}}};
	assign e_end = {1'b0, e_base} + {1'b0, e_len};
	assign e_valid = valid_q[idx_s1];

	always_comb begin
		if (type_q == REQ_MAP) begin
			match = e_valid && ({1'b0, start_q} < e_end) && ({1'b0, e_base} < end_q);
		end else begin
			match = e_valid && (addr_q >= e_base) && ({1'b0, addr_q} < e_end);
		end
	end

	assign do_map = fire && (type_q == REQ_MAP) && !found_q && free_q;
	assign do_unmap = fire && (type_q == REQ_UNMAP) && found_q &&
		(addr_q == fbase_q) && (len_q == flen_q);

	assign ram_we = do_map;
	assign ram_waddr = freeidx_q;
	assign ram_wdata = {start_q[ADDR_W-1:PAGE_SHIFT], mlen_q, perm_q};

	always_comb begin
		res = '0;
		res.status = ST_NOT_FOUND;
		unique case (type_q)
			REQ_MAP: begin
				if (found_q) begin
					res.status = ST_OVERLAP;
					res.slot = SLOT_W'(fidx_q);
					res.base = fbase_q;
					res.length = flen_q;
					res.perm = fperm_q;
				end else if (!free_q) begin
					res.status = ST_FULL;
					res.base = start_q;
					res.length = mlen_q;
					res.perm = perm_q;
				end else begin
					res.status = ST_OK;
					res.hit = 1'b1;
					res.slot = SLOT_W'(freeidx_q);
					res.base = start_q;
					res.length = mlen_q;
					res.perm = perm_q;
				end
			end
			REQ_LOOKUP, REQ_UNMAP: begin
				if (found_q) begin
					res.hit = 1'b1;
					res.slot = SLOT_W'(fidx_q);
					res.base = fbase_q;
					res.length = flen_q;
					res.perm = fperm_q;
					if (type_q == REQ_UNMAP &&
						(addr_q != fbase_q || len_q != flen_q)) begin
						res.status = ST_PARTIAL;
					end else begin
						res.status = ST_OK;
					end
				end
			end
			default: begin
				res.status = ST_NOT_FOUND;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			chk_s1 <= 1'b0;
			found_q <= 1'b0;
			free_q <= 1'b0;
			for (int i = 0; i < MAX_REGIONS; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else begin
			chk_s1 <= ram_re;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SCAN;
						idx_q <= '0;
						found_q <= 1'b0;
						free_q <= 1'b0;
					end
				end
				S_SCAN: begin
					if (idx_q == LAST) begin
						state_q <= S_WAIT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_WAIT: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (chk_s1) begin
				if (match && !found_q) begin
					found_q <= 1'b1;
				end
				if (!e_valid && !free_q) begin
					free_q <= 1'b1;
				end
			end
			if (do_map) begin
				valid_q[freeidx_q] <= 1'b1;
			end
			if (do_unmap) begin
				valid_q[fidx_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		end_q <= {1'b0, start_q} + {1'b0, mlen_q};
		if (accept) begin
			type_q <= req_t'(req_type);
			addr_q <= a_m;
			len_q <= length;
			start_q <= start_c;
			mlen_q <= mlen_c;
			perm_q <= perm;
		end
		if (chk_s1 && match && !found_q) begin
			fidx_q <= idx_s1;
			fbase_q <= e_base;
			flen_q <= e_len;
			fperm_q <= e_perm;
		end
		if (chk_s1 && !e_valid && !free_q) begin
			freeidx_q <= idx_s1;
		end
	end

endmodule

### tb/testbench.sv
module testbench;
	import art_pkg::*;

	localparam int SLOTS = MAX_REGIONS_DEF;
	localparam longint unsigned PAGE = PAGE_BYTES_DEF;
	localparam longint unsigned SPACE = 64'd1 << ADDR_BITS;
	localparam logic [1:0] REQ_UNDEFINED = 2'd3;
	localparam int RANDOM_ITEMS = 1800;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE_CYCLES = 60;

	class region_book;
		bit                 used [SLOTS];
		logic [ADDR_W-1:0]  page [SLOTS];
		logic [LEN_W-1:0]   span [SLOTS];
		logic [PERM_W-1:0]  rights [SLOTS];
		result_t            awaited [$];
		int                 tally [5];
		int                 mismatches;
		int                 checked;

		function logic [63:0] base_of(int i);
			return 64'(page[i]) * PAGE;
		endfunction

		function int holder(logic [63:0] a);
			for (int i = 0; i < SLOTS; i++)
				if (used[i] && a >= base_of(i) && a < base_of(i) + 64'(span[i]))
					return i;
			return -1;
		endfunction

		function result_t region_of(int i, status_t st);
			result_t r;
			r.status = st;
			r.hit = 1'b1;
			r.slot = SLOT_W'(i);
			r.base = ADDR_W'(base_of(i));
			r.length = span[i];
			r.perm = rights[i];
			return r;
		endfunction

		function void take_request(logic [1:0] kind, logic [ADDR_W-1:0] a_in,
				logic [LEN_W-1:0] len_in, logic [PERM_W-1:0] p);
			logic [63:0] a, start, len, stop, s;
			int free_at, h;
			result_t r;
			a = 64'(a_in & ADDR_MASK);
			len = 64'(len_in);
			r = '0;
			r.status = ST_NOT_FOUND;
			case (kind)
				REQ_MAP: begin
					start = a - (a % PAGE);
					if (len < PAGE)
						len = PAGE;
					stop = start + len;
					free_at = -1;
					h = -1;
					for (int i = 0; i < SLOTS; i++) begin
						if (used[i]) begin
							s = base_of(i);
							if (h < 0 && start < s + 64'(span[i]) && s < stop)
								h = i;
						end else if (free_at < 0) begin
							free_at = i;
						end
					end
					if (h >= 0) begin
						r = region_of(h, ST_OVERLAP);
						r.hit = 1'b0;
					end else if (free_at < 0) begin
						r.status = ST_FULL;
						r.base = start[ADDR_W-1:0];
						r.length = len[LEN_W-1:0];
						r.perm = p;
					end else begin
						used[free_at] = 1'b1;
						page[free_at] = ADDR_W'(start / PAGE);
						span[free_at] = len[LEN_W-1:0];
						rights[free_at] = p;
						r = region_of(free_at, ST_OK);
					end
				end
				REQ_LOOKUP, REQ_UNMAP: begin
					h = holder(a);
					if (h >= 0) begin
						if (kind == REQ_LOOKUP) begin
							r = region_of(h, ST_OK);
						end else if (a != base_of(h) || len != 64'(span[h])) begin
							r = region_of(h, ST_PARTIAL);
						end else begin
							r = region_of(h, ST_OK);
							used[h] = 1'b0;
						end
					end
				end
				default: ;
			endcase
			tally[r.status]++;
			awaited.push_back(r);
		endfunction

		task report_mismatch(string what);
			mismatches++;
			$display("Mismatch at result %0d: %s", checked, what);
		endtask

		task match_response(result_t got);
			result_t want;
			checked++;
			if (awaited.size() == 0) begin
				report_mismatch("result arrived with nothing outstanding");
				return;
			end
			want = awaited.pop_front();
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
			if (got.hit !== want.hit)
				report_mismatch($sformatf("hit %0d, expected %0d", got.hit, want.hit));
			if (got.slot !== want.slot)
				report_mismatch($sformatf("slot %0d, expected %0d", got.slot, want.slot));
			if (got.base !== want.base)
				report_mismatch($sformatf("region_base %h, expected %h", got.base, want.base));
			if (got.length !== want.length)
				report_mismatch($sformatf("region_length %h, expected %h",
					got.length, want.length));
			if (got.perm !== want.perm)
				report_mismatch($sformatf("region_perm %h, expected %h", got.perm, want.perm));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         req_type;
	logic [ADDR_W-1:0]  addr;
	logic [LEN_W-1:0]   length;
	logic [PERM_W-1:0]  perm;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [2:0]         status;
	logic               hit;
	logic [SLOT_W-1:0]  slot;
	logic [ADDR_W-1:0]  region_base;
	logic [LEN_W-1:0]   region_length;
	logic [PERM_W-1:0]  region_perm;

	region_book book = new();
	bit steady = 1'b0;
	int sent = 0;
	int clock_count = 0;

	address_region_table_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.addr(addr),
		.length(length),
		.perm(perm),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.hit(hit),
		.slot(slot),
		.region_base(region_base),
		.region_length(region_length),
		.region_perm(region_perm)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		clock_count <= clock_count + 1;
		if (clock_count == CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles without finishing.", CYCLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				book.match_response(result_t'({status, hit, slot, region_base,
					region_length, region_perm}));
			if (in_valid && !in_stall)
				book.take_request(req_type, addr, length, perm);
		end
	end

	always @(negedge clk)
		out_stall <= !steady && ($urandom_range(0, 99) < 14);

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] rand_addr();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5:
				return 64'($urandom_range(0, 63)) * PAGE + 64'($urandom_range(0, PAGE - 1));
			6, 7: return rand64() & (SPACE - 1);
			default: return SPACE - 1 - 64'($urandom_range(0, 40000));
		endcase
	endfunction

	function automatic logic [63:0] rand_len();
		case ($urandom_range(0, 9))
			0, 1, 2: return 64'($urandom_range(0, 8 * PAGE));
			3, 4, 5: return 64'($urandom_range(1, 4)) * PAGE;
			6, 7: return 64'($urandom_range(0, PAGE - 1));
			8: return 64'($urandom_range(1, 63)) * PAGE;
			default: return rand64() & (SPACE - 1);
		endcase
	endfunction

	function automatic logic [63:0] inside_region(int i);
		logic [63:0] base, room;
		base = book.base_of(i);
		room = 64'(book.span[i]);
		if (base + room > SPACE)
			room = SPACE - base;
		return base + (rand64() % room);
	endfunction

	task automatic send_item(input logic [1:0] kind, input logic [ADDR_W-1:0] a,
			input logic [LEN_W-1:0] len, input logic [PERM_W-1:0] p);
		int gap;
		gap = 0;
		if (!steady && $urandom_range(0, 99) < 14)
			gap = $urandom_range(1, 30);
		repeat (gap) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		req_type = kind;
		addr = a;
		length = len;
		perm = p;
		do @(posedge clk); while (in_stall);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (book.awaited.size() != 0)
			@(negedge clk);
	endtask

	task automatic random_item();
		int choice, held, pick;
		logic [63:0] a, len;
		logic [1:0] kind;
		held = 0;
		for (int i = 0; i < SLOTS; i++)
			held += book.used[i];
		pick = -1;
		if (held != 0) begin
			pick = $urandom_range(0, SLOTS - 1);
			while (!book.used[pick])
				pick = (pick + 1) % SLOTS;
		end
		choice = $urandom_range(0, 99);
		a = rand_addr();
		len = rand_len();
		if (choice < (held == SLOTS ? 30 : 45)) begin
			kind = REQ_MAP;
		end else if (choice < 75) begin
			kind = REQ_LOOKUP;
			if (pick >= 0 && $urandom_range(0, 3) != 0)
				a = inside_region(pick);
		end else if (choice < 97) begin
			kind = REQ_UNMAP;
			if (pick >= 0 && $urandom_range(0, 3) != 0) begin
				a = book.base_of(pick);
				len = 64'(book.span[pick]);
				case ($urandom_range(0, 3))
					0: a = inside_region(pick);
					1: len = len + 64'($urandom_range(0, 1)) * 2 - 1;
					default: ;
				endcase
			end
		end else begin
			kind = REQ_UNDEFINED;
		end
		send_item(kind, a[ADDR_W-1:0], len[LEN_W-1:0], PERM_W'($urandom));
	endtask

	initial begin
		in_valid = 1'b0;
		req_type = REQ_MAP;
		addr = '0;
		length = '0;
		perm = '0;
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_item(REQ_LOOKUP, 48'h0, 48'h0, 4'h0);
		send_item(REQ_UNMAP, 48'h0, 48'h1000, 4'h0);
		send_item(REQ_MAP, 48'h0, 48'h0, 4'h0);
		send_item(REQ_MAP, 48'hFFF, 48'h1, 4'hF);
		send_item(REQ_MAP, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 4'hF);
		send_item(REQ_LOOKUP, 48'hFFFF_FFFF_FFFF, 48'h0, 4'h0);
		send_item(REQ_MAP, 48'h5000, 48'h1801, 4'h5);
		send_item(REQ_LOOKUP, 48'h6800, 48'h0, 4'h0);
		send_item(REQ_LOOKUP, 48'h6801, 48'h0, 4'h0);
		send_item(REQ_UNMAP, 48'h5001, 48'h1801, 4'h0);
		send_item(REQ_UNMAP, 48'h5000, 48'h1800, 4'h0);
		send_item(REQ_UNMAP, 48'h5000, 48'h1801, 4'h0);
		send_item(REQ_LOOKUP, 48'h5000, 48'h0, 4'h0);
		send_item(REQ_UNDEFINED, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 4'hF);
		send_item(REQ_MAP, 48'h2000, 48'h2000, 4'hA);
		send_item(REQ_MAP, 48'h1000, 48'h4000, 4'h1);
		send_item(REQ_MAP, 48'h3000, 48'h1000, 4'h2);
		send_item(REQ_MAP, 48'h1000, 48'h1000, 4'h3);
		send_item(REQ_MAP, 48'h4000, 48'hFFF, 4'h6);
		send_item(REQ_UNMAP, 48'hFFFF_FFFF_F000, 48'hFFFF_FFFF_FFFF, 4'h0);
		drain();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady = (n >= 700 && n < 1000);
			if (n % 450 == 449)
				drain();
			random_item();
		end
		in_valid = 1'b0;
		while (book.awaited.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Drove %0d items; outcomes: %0d ok, %0d overlap, %0d table full,",
			sent, book.tally[ST_OK], book.tally[ST_OVERLAP], book.tally[ST_FULL]);
		$display("%0d not found, %0d partial unmap; %0d results checked, %0d mismatches.",
			book.tally[ST_NOT_FOUND], book.tally[ST_PARTIAL], book.checked, book.mismatches);
		if (book.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
